FILE: rtl/core/rtlh_pkg.sv
// ----------------------------------------------------------------------------
// rtlh_pkg: shared types and helpers of the ray / triangle list hit unit
// Fixed point helpers, sequencer state, micro term encoding, register map.
// ----------------------------------------------------------------------------
`default_nettype none

package rtlh_pkg;

  localparam int unsigned VAL_W     = 32;
  localparam int unsigned PROD_W    = 64;
  localparam int unsigned ACC_W     = 66;
  localparam int unsigned DIST_W    = 31;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned SQ_IN_W   = 64;
  localparam int unsigned SQ_OUT_W  = 32;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ORIGIN_X    = 3'd0,
    REG_ORIGIN_Y    = 3'd1,
    REG_ORIGIN_Z    = 3'd2,
    REG_DIRECTION_X = 3'd3,
    REG_DIRECTION_Y = 3'd4,
    REG_DIRECTION_Z = 3'd5,
    REG_FIRST_HIT   = 3'd6
  } cfg_reg_t;

  typedef enum logic [14:0] {
    S_IDLE   = 15'b000000000000001,
    S_SUBA   = 15'b000000000000010,
    S_CROSS  = 15'b000000000000100,
    S_SQ     = 15'b000000000001000,
    S_SQRT   = 15'b000000000010000,
    S_UDIV   = 15'b000000000100000,
    S_DOTD   = 15'b000000001000000,
    S_DOTW   = 15'b000000010000000,
    S_CHECK  = 15'b000000100000000,
    S_TDIV   = 15'b000001000000000,
    S_PT     = 15'b000010000000000,
    S_ESUB   = 15'b000100000000000,
    S_EDOT   = 15'b001000000000000,
    S_ECHK   = 15'b010000000000000,
    S_FINISH = 15'b100000000000000
  } state_t;

  // operand sources of the shared multiplier
  typedef enum logic [2:0] {
    A_E1 = 3'd0,
    A_N  = 3'd1,
    A_D  = 3'd2,
    A_W  = 3'd3,
    A_T  = 3'd4
  } asel_t;

  typedef enum logic [1:0] {
    B_E2 = 2'd0,
    B_N  = 2'd1,
    B_U  = 2'd2,
    B_D  = 2'd3
  } bsel_t;

  typedef enum logic [2:0] {
    DST_N    = 3'd0,
    DST_S    = 3'd1,
    DST_VN   = 3'd2,
    DST_XPN  = 3'd3,
    DST_P    = 3'd4,
    DST_EDGE = 3'd5
  } dst_t;

  typedef struct packed {
    asel_t      a_sel;
    logic [1:0] a_c;
    bsel_t      b_sel;
    logic [1:0] b_c;
    logic       shift;
    logic       sub;
    logic       first;
    logic       last;
    logic       base_o;
    dst_t       dst;
    logic [1:0] dst_c;
  } term_t;

  function automatic logic signed [VAL_W-1:0] sat32(input logic signed [ACC_W-1:0] x);
    if (x > 66'sh0_7FFF_FFFF) begin
      return 32'sh7FFF_FFFF;
    end else if (x < -66'sh0_8000_0000) begin
      return 32'sh8000_0000;
    end else begin
      return $signed(x[VAL_W-1:0]);
    end
  endfunction

  function automatic logic signed [VAL_W-1:0] sub_sat(input logic signed [VAL_W-1:0] x,
                                                      input logic signed [VAL_W-1:0] y);
    logic signed [VAL_W:0] d;
    d = $signed({x[VAL_W-1], x}) - $signed({y[VAL_W-1], y});
    return sat32($signed({{(ACC_W-VAL_W-1){d[VAL_W]}}, d}));
  endfunction

  function automatic logic [VAL_W-1:0] mag32(input logic signed [VAL_W-1:0] x);
    return x[VAL_W-1] ? VAL_W'(-x) : VAL_W'(x);
  endfunction

  function automatic logic [1:0] next_c(input logic [1:0] c);
    return (c == 2'd2) ? 2'd0 : c + 2'd1;
  endfunction

endpackage

`default_nettype wire

FILE: rtl/core/rtlh_tri_if.sv
// ----------------------------------------------------------------------------
// rtlh_tri_if: triangle channel
// valid / ready channel carrying three corners and the end-of-list mark.
// ----------------------------------------------------------------------------
`default_nettype none

interface rtlh_tri_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] corner_a_x;
  logic signed [31:0] corner_a_y;
  logic signed [31:0] corner_a_z;
  logic signed [31:0] corner_b_x;
  logic signed [31:0] corner_b_y;
  logic signed [31:0] corner_b_z;
  logic signed [31:0] corner_c_x;
  logic signed [31:0] corner_c_y;
  logic signed [31:0] corner_c_z;
  logic               last_triangle;

  modport source (
    output valid, corner_a_x, corner_a_y, corner_a_z, corner_b_x, corner_b_y, corner_b_z,
           corner_c_x, corner_c_y, corner_c_z, last_triangle,
    input  ready
  );
  modport sink (
    input  valid, corner_a_x, corner_a_y, corner_a_z, corner_b_x, corner_b_y, corner_b_z,
           corner_c_x, corner_c_y, corner_c_z, last_triangle,
    output ready
  );
endinterface

`default_nettype wire

FILE: rtl/core/rtlh_res_if.sv
// ----------------------------------------------------------------------------
// rtlh_res_if: result channel
// valid / ready channel carrying the hit flag and hit distance of one list.
// ----------------------------------------------------------------------------
`default_nettype none

interface rtlh_res_if;
  logic        valid;
  logic        ready;
  logic        hit;
  logic [30:0] hit_distance;

  modport source (output valid, hit, hit_distance, input ready);
  modport sink (input valid, hit, hit_distance, output ready);
endinterface

`default_nettype wire

FILE: rtl/core/rtlh_mul.sv
// ----------------------------------------------------------------------------
// rtlh_mul: shared signed multiplier
// 32x32 signed product, optionally floor-shifted by the fraction width, registered.
// ----------------------------------------------------------------------------
`default_nettype none

module rtlh_mul #(
  parameter int FRAC_BITS = 16
) (
  input  logic                                   clk,
  input  logic signed [rtlh_pkg::VAL_W-1:0]      a,
  input  logic signed [rtlh_pkg::VAL_W-1:0]      b,
  input  logic                                   shift,
  output logic signed [rtlh_pkg::PROD_W-1:0]     p_r
);

  logic signed [rtlh_pkg::PROD_W-1:0] prod;

  assign prod = rtlh_pkg::PROD_W'(a) * rtlh_pkg::PROD_W'(b);

  // arithmetic shift gives floor for negative products
  always_ff @(posedge clk) begin
    p_r <= shift ? (prod >>> FRAC_BITS) : prod;
  end

endmodule

`default_nettype wire

FILE: rtl/core/rtlh_div.sv
// ----------------------------------------------------------------------------
// rtlh_div: iterative unsigned divider
// Restoring division, one quotient bit per cycle, done pulse after NUM_W steps.
// ----------------------------------------------------------------------------
`default_nettype none

module rtlh_div #(
  parameter int NUM_W = 48,
  parameter int DEN_W = 32
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  output logic             done_r,
  output logic [NUM_W-1:0] quo
);

  localparam int CNT_W = $clog2(NUM_W);

  logic [NUM_W-1:0] num_r;
  logic [DEN_W-1:0] rem_r;
  logic [DEN_W-1:0] den_r;
  logic [CNT_W-1:0] cnt_r;
  logic             busy_r;
  logic [DEN_W:0]   trial;
  logic             ge;

  assign trial = {rem_r, num_r[NUM_W-1]};
  assign ge    = trial >= {1'b0, den_r};
  assign quo   = num_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + CNT_W'(1);
        if (cnt_r == CNT_W'(NUM_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // quotient bits shift in behind the numerator
  always_ff @(posedge clk) begin
    if (start) begin
      num_r <= num;
      den_r <= den;
      rem_r <= '0;
    end else if (busy_r) begin
      num_r <= {num_r[NUM_W-2:0], ge};
      rem_r <= ge ? DEN_W'(trial - {1'b0, den_r}) : trial[DEN_W-1:0];
    end
  end

endmodule

`default_nettype wire

FILE: rtl/core/rtlh_sqrt.sv
// ----------------------------------------------------------------------------
// rtlh_sqrt: iterative integer square root
// Bitwise floor square root of a 64-bit value, one result bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module rtlh_sqrt (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  input  logic [rtlh_pkg::SQ_IN_W-1:0]      s,
  output logic                              done_r,
  output logic [rtlh_pkg::SQ_OUT_W-1:0]     root
);

  localparam int W     = rtlh_pkg::SQ_IN_W;
  localparam int CNT_W = $clog2(rtlh_pkg::SQ_OUT_W);

  logic [W-1:0]     s_r;
  logic [W-1:0]     res_r;
  logic [W-1:0]     bit_r;
  logic [CNT_W-1:0] cnt_r;
  logic             busy_r;
  logic [W-1:0]     trial;
  logic             ge;

  assign trial = res_r + bit_r;
  assign ge    = s_r >= trial;
  assign root  = res_r[rtlh_pkg::SQ_OUT_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + CNT_W'(1);
        if (cnt_r == CNT_W'(rtlh_pkg::SQ_OUT_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      s_r   <= s;
      res_r <= '0;
      bit_r <= W'(1) << (W - 2);
    end else if (busy_r) begin
      if (ge) begin
        s_r   <= s_r - trial;
        res_r <= (res_r >> 1) + bit_r;
      end else begin
        res_r <= res_r >> 1;
      end
      bit_r <= bit_r >> 2;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/core/ray_triangle_list_hit_unit.sv
// ----------------------------------------------------------------------------
// ray_triangle_list_hit_unit: ray against a streamed triangle list
// Finds the closest (or first) hit of one configured ray over a triangle list.
// ----------------------------------------------------------------------------
// usage
//   - cfg port: write origin, direction and first-hit mode while the block
//     is idle; a write lands at the clock edge where cfg_we is high
//   - in_tri: one beat per triangle (three Q16.16 corners plus the list end
//     mark); in_tri.ready is high only while the sequencer is idle
//   - out_res: one beat per list, issued after the triangle marked last;
//     hit_distance is the kept ray parameter, 0 on a miss
//   - triangle test time is set by the serial divider (4 divides of 32+FRAC_BITS
//     steps) and the 32-step square root; rejected triangles finish earlier,
//     and a triangle skipped in first-hit mode goes straight to the finish
//     state
//   - all products go through one shared 32x32 multiplier, one term a cycle
//   - a finished result sits in an output register; the next triangle is
//     accepted while it waits, only a new end-of-list result stalls until
//     the previous beat is taken
//   - reset: ray origin 0, direction +z, closest mode, no pending hit
// ----------------------------------------------------------------------------
`default_nettype none

module ray_triangle_list_hit_unit #(
  parameter int FRAC_BITS = 16
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_we,
  input  logic [rtlh_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [31:0]                        cfg_data,
  rtlh_tri_if.sink                           in_tri,
  rtlh_res_if.source                         out_res
);

  localparam int VW    = rtlh_pkg::VAL_W;
  localparam int AW    = rtlh_pkg::ACC_W;
  localparam int PW    = rtlh_pkg::PROD_W;
  localparam int DW    = rtlh_pkg::DIST_W;
  localparam int NUM_W = VW + FRAC_BITS;
  localparam int EPS_Q = ((1 << FRAC_BITS) + 50000) / 100000;
  localparam logic signed [VW-1:0] NEG_EPS = -$signed(VW'(EPS_Q));

  // ray registers
  logic signed [VW-1:0] o_r [3];
  logic signed [VW-1:0] d_r [3];
  logic                 first_mode_r;

  // triangle and working registers
  logic signed [VW-1:0] a_r [3];
  logic signed [VW-1:0] b_r [3];
  logic signed [VW-1:0] c_r [3];
  logic                 last_r;
  logic signed [VW-1:0] e1_r [3];
  logic signed [VW-1:0] e2_r [3];
  logic signed [VW-1:0] w_r [3];    // a - origin, later the hit point
  logic signed [VW-1:0] n_r [3];    // face normal, later the edge cross
  logic signed [VW-1:0] u_r [3];    // unit normal
  logic [PW-1:0]        s_r;        // squared normal length
  logic [VW-1:0]        l_r;        // normal length
  logic signed [VW-1:0] vn_r;
  logic signed [VW-1:0] xpn_r;
  logic signed [VW-1:0] t_r;
  logic                 eneg_r;

  // sequencer
  rtlh_pkg::state_t     state_r;
  logic [2:0]           tcnt_r;
  logic [1:0]           ccnt_r;
  logic [1:0]           eidx_r;
  logic                 edges_r;
  logic                 run_r;
  logic                 tri_hit_r;
  logic                 hit_seen_r;
  logic [DW-1:0]        best_r;
  logic                 out_valid_r;
  logic                 out_hit_r;
  logic [DW-1:0]        out_dist_r;

  // micro terms
  rtlh_pkg::term_t      term;
  rtlh_pkg::term_t      ctl_r;
  logic                 ctl_valid_r;
  logic [2:0]           nterms;
  logic                 term_state;
  logic                 issue;
  logic                 phase_end;

  logic signed [VW-1:0] op_a;
  logic signed [VW-1:0] op_b;
  logic signed [PW-1:0] prod_r;
  logic signed [AW-1:0] prod_ext;
  logic signed [AW-1:0] acc_r;
  logic signed [AW-1:0] acc_base;
  logic signed [AW-1:0] acc_nxt;
  logic signed [VW-1:0] acc_sat;

  logic signed [VW-1:0] x1 [3];
  logic signed [VW-1:0] y1 [3];
  logic signed [VW-1:0] x2 [3];
  logic signed [VW-1:0] y2 [3];

  logic                 sq_start;
  logic                 sq_done;
  logic [VW-1:0]        sq_root;
  logic                 div_start;
  logic                 div_done;
  logic [NUM_W-1:0]     div_num;
  logic [VW-1:0]        div_den;
  logic [NUM_W-1:0]     div_quo;

  logic                 accept;
  logic                 fin_seen;
  logic [DW-1:0]        fin_best;

  assign accept         = in_tri.valid && in_tri.ready;
  assign in_tri.ready   = (state_r == rtlh_pkg::S_IDLE);
  assign out_res.valid  = out_valid_r;
  assign out_res.hit    = out_hit_r;
  assign out_res.hit_distance = out_dist_r;

  // ------------------------------------------------------------------------
  // configuration
  // ------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      o_r[0]       <= '0;
      o_r[1]       <= '0;
      o_r[2]       <= '0;
      d_r[0]       <= '0;
      d_r[1]       <= '0;
      d_r[2]       <= $signed(VW'(1) << FRAC_BITS);
      first_mode_r <= 1'b0;
    end else if (cfg_we) begin
      case (rtlh_pkg::cfg_reg_t'(cfg_index))
        rtlh_pkg::REG_ORIGIN_X:    o_r[0] <= $signed(cfg_data);
        rtlh_pkg::REG_ORIGIN_Y:    o_r[1] <= $signed(cfg_data);
        rtlh_pkg::REG_ORIGIN_Z:    o_r[2] <= $signed(cfg_data);
        rtlh_pkg::REG_DIRECTION_X: d_r[0] <= $signed(cfg_data);
        rtlh_pkg::REG_DIRECTION_Y: d_r[1] <= $signed(cfg_data);
        rtlh_pkg::REG_DIRECTION_Z: d_r[2] <= $signed(cfg_data);
        rtlh_pkg::REG_FIRST_HIT:   first_mode_r <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // ------------------------------------------------------------------------
  // micro term decode: one multiplier term per cycle
  // ------------------------------------------------------------------------
  always_comb begin
    term        = '0;
    term.a_c    = tcnt_r[1:0];
    term.b_c    = tcnt_r[1:0];
    term.dst_c  = tcnt_r[1:0];
    term.shift  = 1'b1;
    term.first  = (tcnt_r == 3'd0);
    term.last   = (tcnt_r == 3'd2);
    term.a_sel  = rtlh_pkg::A_N;
    term.b_sel  = rtlh_pkg::B_U;
    term.dst    = rtlh_pkg::DST_EDGE;
    nterms      = 3'd3;
    term_state  = 1'b1;
    case (state_r)
      rtlh_pkg::S_CROSS: begin
        // component g: a[g+1]*b[g+2] - a[g+2]*b[g+1]
        nterms      = 3'd6;
        term.a_sel  = rtlh_pkg::A_E1;
        term.b_sel  = rtlh_pkg::B_E2;
        term.dst    = rtlh_pkg::DST_N;
        term.dst_c  = tcnt_r[2:1];
        term.first  = !tcnt_r[0];
        term.last   = tcnt_r[0];
        term.sub    = tcnt_r[0];
        if (!tcnt_r[0]) begin
          term.a_c = rtlh_pkg::next_c(tcnt_r[2:1]);
          term.b_c = rtlh_pkg::next_c(rtlh_pkg::next_c(tcnt_r[2:1]));
        end else begin
          term.a_c = rtlh_pkg::next_c(rtlh_pkg::next_c(tcnt_r[2:1]));
          term.b_c = rtlh_pkg::next_c(tcnt_r[2:1]);
        end
      end
      rtlh_pkg::S_SQ: begin
        term.a_sel = rtlh_pkg::A_N;
        term.b_sel = rtlh_pkg::B_N;
        term.shift = 1'b0;
        term.dst   = rtlh_pkg::DST_S;
      end
      rtlh_pkg::S_DOTD: begin
        term.a_sel = rtlh_pkg::A_D;
        term.dst   = rtlh_pkg::DST_VN;
      end
      rtlh_pkg::S_DOTW: begin
        term.a_sel = rtlh_pkg::A_W;
        term.dst   = rtlh_pkg::DST_XPN;
      end
      rtlh_pkg::S_EDOT: begin
        term.a_sel = rtlh_pkg::A_N;
        term.dst   = rtlh_pkg::DST_EDGE;
      end
      rtlh_pkg::S_PT: begin
        // hit point: origin + t * direction, one term per component
        term.a_sel  = rtlh_pkg::A_T;
        term.b_sel  = rtlh_pkg::B_D;
        term.first  = 1'b1;
        term.last   = 1'b1;
        term.base_o = 1'b1;
        term.dst    = rtlh_pkg::DST_P;
      end
      default: begin
        term_state = 1'b0;
      end
    endcase
  end

  assign phase_end = term_state && (tcnt_r == nterms);
  assign issue     = term_state && (tcnt_r != nterms);

  always_comb begin
    case (term.a_sel)
      rtlh_pkg::A_E1: op_a = e1_r[term.a_c];
      rtlh_pkg::A_N:  op_a = n_r[term.a_c];
      rtlh_pkg::A_D:  op_a = d_r[term.a_c];
      rtlh_pkg::A_W:  op_a = w_r[term.a_c];
      rtlh_pkg::A_T:  op_a = t_r;
      default:        op_a = '0;
    endcase
    case (term.b_sel)
      rtlh_pkg::B_E2: op_b = e2_r[term.b_c];
      rtlh_pkg::B_N:  op_b = n_r[term.b_c];
      rtlh_pkg::B_U:  op_b = u_r[term.b_c];
      rtlh_pkg::B_D:  op_b = d_r[term.b_c];
      default:        op_b = '0;
    endcase
  end

  rtlh_mul #(.FRAC_BITS(FRAC_BITS)) u_mul (
    .clk   (clk),
    .a     (op_a),
    .b     (op_b),
    .shift (term.shift),
    .p_r   (prod_r)
  );

  // term control is registered in step with the product, so it travels alongside it
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_valid_r <= 1'b0;
    end else begin
      ctl_valid_r <= issue;
    end
  end

  always_ff @(posedge clk) begin
    ctl_r <= term;
  end

  // accumulator: exact sum of terms, saturated once at group end
  assign prod_ext = $signed({{(AW-PW){prod_r[PW-1]}}, prod_r});
  assign acc_base = ctl_r.base_o ? $signed({{(AW-VW){o_r[ctl_r.dst_c][VW-1]}},
                                            o_r[ctl_r.dst_c]})
                                 : '0;
  always_comb begin
    if (ctl_r.first) begin
      acc_nxt = ctl_r.sub ? acc_base - prod_ext : acc_base + prod_ext;
    end else begin
      acc_nxt = ctl_r.sub ? acc_r - prod_ext : acc_r + prod_ext;
    end
  end
  assign acc_sat = rtlh_pkg::sat32(acc_nxt);

  always_ff @(posedge clk) begin
    if (ctl_valid_r) begin
      acc_r <= acc_nxt;
    end
  end

  // ------------------------------------------------------------------------
  // edge vector subtractors
  // ------------------------------------------------------------------------
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      if (!edges_r) begin
        x1[k] = b_r[k];
        y1[k] = a_r[k];
        x2[k] = c_r[k];
        y2[k] = a_r[k];
      end else begin
        x1[k] = w_r[k];
        case (eidx_r)
          2'd0: begin
            y1[k] = b_r[k];
            x2[k] = a_r[k];
          end
          2'd1: begin
            y1[k] = c_r[k];
            x2[k] = b_r[k];
          end
          default: begin
            y1[k] = a_r[k];
            x2[k] = c_r[k];
          end
        endcase
        y2[k] = y1[k];
      end
    end
  end

  // ------------------------------------------------------------------------
  // square root and divider
  // ------------------------------------------------------------------------
  assign sq_start  = (state_r == rtlh_pkg::S_SQRT) && !run_r;
  assign div_start = ((state_r == rtlh_pkg::S_UDIV) || (state_r == rtlh_pkg::S_TDIV)) && !run_r;

  always_comb begin
    if (state_r == rtlh_pkg::S_UDIV) begin
      div_num = NUM_W'(rtlh_pkg::mag32(n_r[ccnt_r])) << FRAC_BITS;
      div_den = l_r;
    end else begin
      div_num = NUM_W'(rtlh_pkg::mag32(xpn_r)) << FRAC_BITS;
      div_den = rtlh_pkg::mag32(vn_r);
    end
  end

  rtlh_sqrt u_sqrt (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (sq_start),
    .s      (s_r),
    .done_r (sq_done),
    .root   (sq_root)
  );

  rtlh_div #(.NUM_W(NUM_W), .DEN_W(VW)) u_div (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (div_start),
    .num    (div_num),
    .den    (div_den),
    .done_r (div_done),
    .quo    (div_quo)
  );

  // ------------------------------------------------------------------------
  // datapath registers
  // ------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (accept) begin
      a_r[0] <= in_tri.corner_a_x;
      a_r[1] <= in_tri.corner_a_y;
      a_r[2] <= in_tri.corner_a_z;
      b_r[0] <= in_tri.corner_b_x;
      b_r[1] <= in_tri.corner_b_y;
      b_r[2] <= in_tri.corner_b_z;
      c_r[0] <= in_tri.corner_c_x;
      c_r[1] <= in_tri.corner_c_y;
      c_r[2] <= in_tri.corner_c_z;
      last_r <= in_tri.last_triangle;
    end
    if ((state_r == rtlh_pkg::S_SUBA) || (state_r == rtlh_pkg::S_ESUB)) begin
      for (int k = 0; k < 3; k++) begin
        e1_r[k] <= rtlh_pkg::sub_sat(x1[k], y1[k]);
        e2_r[k] <= rtlh_pkg::sub_sat(x2[k], y2[k]);
      end
    end
    if (state_r == rtlh_pkg::S_SUBA) begin
      for (int k = 0; k < 3; k++) begin
        w_r[k] <= rtlh_pkg::sub_sat(a_r[k], o_r[k]);
      end
    end
    if (ctl_valid_r && ctl_r.last) begin
      case (ctl_r.dst)
        rtlh_pkg::DST_N:    n_r[ctl_r.dst_c] <= acc_sat;
        rtlh_pkg::DST_S:    s_r <= acc_nxt[PW-1:0];
        rtlh_pkg::DST_VN:   vn_r <= acc_sat;
        rtlh_pkg::DST_XPN:  xpn_r <= acc_sat;
        rtlh_pkg::DST_P:    w_r[ctl_r.dst_c] <= acc_sat;
        rtlh_pkg::DST_EDGE: eneg_r <= acc_nxt[AW-1];
        default: ;
      endcase
    end
    if ((state_r == rtlh_pkg::S_SQRT) && sq_done) begin
      l_r <= sq_root;
    end
    if ((state_r == rtlh_pkg::S_UDIV) && div_done) begin
      // |u| never exceeds one, so the low word holds the quotient
      u_r[ccnt_r] <= n_r[ccnt_r][VW-1] ? -$signed(div_quo[VW-1:0])
                                       : $signed(div_quo[VW-1:0]);
    end
    if ((state_r == rtlh_pkg::S_TDIV) && div_done) begin
      t_r <= (|div_quo[NUM_W-1:DW]) ? $signed({1'b0, {DW{1'b1}}})
                                    : $signed({1'b0, div_quo[DW-1:0]});
    end
  end

  // list state after this triangle
  assign fin_seen = hit_seen_r || tri_hit_r;
  assign fin_best = (tri_hit_r && (!hit_seen_r || (t_r[DW-1:0] < best_r))) ? t_r[DW-1:0]
                                                                          : best_r;

  // ------------------------------------------------------------------------
  // sequencer
  // ------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= rtlh_pkg::S_IDLE;
      tcnt_r      <= '0;
      ccnt_r      <= '0;
      eidx_r      <= '0;
      edges_r     <= 1'b0;
      run_r       <= 1'b0;
      tri_hit_r   <= 1'b0;
      hit_seen_r  <= 1'b0;
      best_r      <= '0;
      out_valid_r <= 1'b0;
      out_hit_r   <= 1'b0;
      out_dist_r  <= '0;
    end else begin
      // a beat taken while a new list result loads is refilled in the finish arm
      if (out_res.valid && out_res.ready &&
          !((state_r == rtlh_pkg::S_FINISH) && last_r)) begin
        out_valid_r <= 1'b0;
      end
      if (term_state) begin
        tcnt_r <= phase_end ? 3'd0 : tcnt_r + 3'd1;
      end
      case (state_r)
        rtlh_pkg::S_IDLE: begin
          if (accept) begin
            tri_hit_r <= 1'b0;
            edges_r   <= 1'b0;
            tcnt_r    <= '0;
            // first-hit mode ignores the rest of the list once a hit is held
            state_r   <= (first_mode_r && hit_seen_r) ? rtlh_pkg::S_FINISH
                                                      : rtlh_pkg::S_SUBA;
          end
        end
        rtlh_pkg::S_SUBA: begin
          state_r <= rtlh_pkg::S_CROSS;
        end
        rtlh_pkg::S_CROSS: begin
          if (phase_end) begin
            state_r <= edges_r ? rtlh_pkg::S_EDOT : rtlh_pkg::S_SQ;
          end
        end
        rtlh_pkg::S_SQ: begin
          if (phase_end) begin
            state_r <= rtlh_pkg::S_SQRT;
          end
        end
        rtlh_pkg::S_SQRT: begin
          if (sq_done) begin
            run_r <= 1'b0;
            ccnt_r <= '0;
            // zero length normal: degenerate, never a hit
            state_r <= (sq_root == '0) ? rtlh_pkg::S_FINISH : rtlh_pkg::S_UDIV;
          end else if (!run_r) begin
            run_r <= 1'b1;
          end
        end
        rtlh_pkg::S_UDIV: begin
          if (div_done) begin
            run_r <= 1'b0;
            if (ccnt_r == 2'd2) begin
              state_r <= rtlh_pkg::S_DOTD;
            end else begin
              ccnt_r <= ccnt_r + 2'd1;
            end
          end else if (!run_r) begin
            run_r <= 1'b1;
          end
        end
        rtlh_pkg::S_DOTD: begin
          if (phase_end) begin
            state_r <= rtlh_pkg::S_DOTW;
          end
        end
        rtlh_pkg::S_DOTW: begin
          if (phase_end) begin
            state_r <= rtlh_pkg::S_CHECK;
          end
        end
        rtlh_pkg::S_CHECK: begin
          // parallel, back facing, or behind the origin
          if ((vn_r >= NEG_EPS) || (xpn_r > 0)) begin
            state_r <= rtlh_pkg::S_FINISH;
          end else begin
            state_r <= rtlh_pkg::S_TDIV;
          end
        end
        rtlh_pkg::S_TDIV: begin
          if (div_done) begin
            run_r   <= 1'b0;
            state_r <= rtlh_pkg::S_PT;
          end else if (!run_r) begin
            run_r <= 1'b1;
          end
        end
        rtlh_pkg::S_PT: begin
          if (phase_end) begin
            edges_r <= 1'b1;
            eidx_r  <= '0;
            state_r <= rtlh_pkg::S_ESUB;
          end
        end
        rtlh_pkg::S_ESUB: begin
          state_r <= rtlh_pkg::S_CROSS;
        end
        rtlh_pkg::S_EDOT: begin
          if (phase_end) begin
            state_r <= rtlh_pkg::S_ECHK;
          end
        end
        rtlh_pkg::S_ECHK: begin
          if (eneg_r) begin
            state_r <= rtlh_pkg::S_FINISH;
          end else if (eidx_r == 2'd2) begin
            tri_hit_r <= 1'b1;
            state_r   <= rtlh_pkg::S_FINISH;
          end else begin
            eidx_r  <= eidx_r + 2'd1;
            state_r <= rtlh_pkg::S_ESUB;
          end
        end
        rtlh_pkg::S_FINISH: begin
          if (!last_r) begin
            hit_seen_r <= fin_seen;
            best_r     <= fin_best;
            state_r    <= rtlh_pkg::S_IDLE;
          end else if (!out_valid_r || out_res.ready) begin
            // end of list: emit and clear for the next list
            out_valid_r <= 1'b1;
            out_hit_r   <= fin_seen;
            out_dist_r  <= fin_seen ? fin_best : '0;
            hit_seen_r  <= 1'b0;
            best_r      <= '0;
            state_r     <= rtlh_pkg::S_IDLE;
          end
        end
        default: begin
          state_r <= rtlh_pkg::S_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

FILE: sim/tb.sv
// ----------------------------------------------------------------------------
// tb: ray against triangle list hit unit
// Table of hand-made triangles, then random lists under several ray setups,
// each list result checked against a table entry or a fixed-point model of the ray test.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb;

  localparam longint Q          = 65536;
  localparam longint SAT_HI     = 64'sd2147483647;
  localparam longint SAT_LO     = -64'sd2147483648;
  localparam longint NEAR_ZERO  = 1;       // 0.00001 in Q16.16, rounded
  localparam int     CYCLE_CAP  = 1500000;
  localparam int     DRAIN_WAIT = 400;     // about one full triangle test

  typedef struct { longint x, y, z; } vec_t;
  typedef struct { vec_t a, b, c; bit last; } tri_t;
  typedef struct { bit hit; longint distance; } hit_rec_t;
  typedef struct { tri_t tr; bit typed; bit hit; longint distance; } row_t;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 cfg_we = 1'b0;
  rtlh_pkg::cfg_reg_t   cfg_index = rtlh_pkg::REG_ORIGIN_X;
  logic [31:0]          cfg_data = '0;

  rtlh_tri_if in_tri ();
  rtlh_res_if out_res ();

  ray_triangle_list_hit_unit dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_tri    (in_tri.sink),
    .out_res   (out_res.source)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ray setup and list state as the block should hold them
  vec_t     ray_org, ray_dir;
  bit       keep_first;
  bit       list_hit;
  longint   list_best;
  hit_rec_t pending_hits[$];

  int errors = 0;
  int cycles = 0;
  int tri_count = 0;
  int list_count = 0;
  int hit_lists = 0;
  bit quiet = 1'b0;

  // ---------------------------------------------------------------- arithmetic
  function automatic longint sat(longint v);
    if (v > SAT_HI) return SAT_HI;
    if (v < SAT_LO) return SAT_LO;
    return v;
  endfunction

  // exact product, floor shift back to Q16.16
  function automatic longint qmul(longint a, longint b);
    longint p;
    p = a * b;
    return p >>> 16;
  endfunction

  function automatic vec_t vsub(vec_t a, vec_t b);
    vec_t r;
    r.x = sat(a.x - b.x);
    r.y = sat(a.y - b.y);
    r.z = sat(a.z - b.z);
    return r;
  endfunction

  function automatic vec_t vcross(vec_t a, vec_t b);
    vec_t r;
    r.x = sat(qmul(a.y, b.z) - qmul(a.z, b.y));
    r.y = sat(qmul(a.z, b.x) - qmul(a.x, b.z));
    r.z = sat(qmul(a.x, b.y) - qmul(a.y, b.x));
    return r;
  endfunction

  function automatic longint vdot(vec_t a, vec_t b);
    return sat(qmul(a.x, b.x) + qmul(a.y, b.y) + qmul(a.z, b.z));
  endfunction

  function automatic longint unsigned mag(longint v);
    return (v < 0) ? longint'(-v) : longint'(v);
  endfunction

  // 32-step bitwise square root on the raw squared length
  function automatic longint unsigned root_len(longint unsigned s);
    longint unsigned res, bitv;
    res = 0;
    bitv = 64'd1 << 62;
    for (int i = 0; i < 32; i++) begin
      if (s >= res + bitv) begin
        s = s - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res;
  endfunction

  function automatic vec_t unit_normal(vec_t n);
    vec_t u;
    longint unsigned s, len;
    u = '{0, 0, 0};
    s = mag(n.x) * mag(n.x) + mag(n.y) * mag(n.y) + mag(n.z) * mag(n.z);
    len = root_len(s);
    if (len == 0) return u;
    u.x = (n.x < 0) ? -longint'((mag(n.x) << 16) / len) : longint'((mag(n.x) << 16) / len);
    u.y = (n.y < 0) ? -longint'((mag(n.y) << 16) / len) : longint'((mag(n.y) << 16) / len);
    u.z = (n.z < 0) ? -longint'((mag(n.z) << 16) / len) : longint'((mag(n.z) << 16) / len);
    return u;
  endfunction

  function automatic bit inside_edge(vec_t p, vec_t from, vec_t to, vec_t u);
    return vdot(vcross(vsub(p, from), vsub(to, from)), u) >= 0;
  endfunction

  // ray against one triangle, t returned through distance on a hit
  function automatic bit ray_hits(tri_t tr, output longint distance);
    vec_t u, p;
    longint vn, xpn, t;
    distance = 0;
    u = unit_normal(vcross(vsub(tr.b, tr.a), vsub(tr.c, tr.a)));
    vn = vdot(ray_dir, u);
    xpn = vdot(vsub(tr.a, ray_org), u);
    if (vn >= -NEAR_ZERO) return 1'b0;   // parallel or back face
    if (xpn > 0) return 1'b0;            // behind the origin
    t = longint'((mag(xpn) << 16) / mag(vn));
    if (t > SAT_HI) t = SAT_HI;
    p.x = sat(ray_org.x + qmul(t, ray_dir.x));
    p.y = sat(ray_org.y + qmul(t, ray_dir.y));
    p.z = sat(ray_org.z + qmul(t, ray_dir.z));
    if (!inside_edge(p, tr.b, tr.a, u)) return 1'b0;
    if (!inside_edge(p, tr.c, tr.b, u)) return 1'b0;
    if (!inside_edge(p, tr.a, tr.c, u)) return 1'b0;
    distance = t;
    return 1'b1;
  endfunction

  // fold one accepted triangle into the list; a last one yields the list result
  function automatic void fold_triangle(row_t row);
    longint t;
    hit_rec_t rec;
    if (!(keep_first && list_hit) && ray_hits(row.tr, t)) begin
      if (!list_hit || t < list_best) list_best = t;
      list_hit = 1'b1;
    end
    if (!row.tr.last) return;
    rec.hit = list_hit;
    rec.distance = list_hit ? list_best : 0;
    if (row.typed) begin
      rec.hit = row.hit;
      rec.distance = row.distance;
    end
    pending_hits.push_back(rec);
    list_hit = 1'b0;
    list_best = 0;
  endfunction

  // ---------------------------------------------------------------- checking
  task automatic report(string what, longint got, longint want);
    errors++;
    $display("[%0t] mismatch: %s got %0d expected %0d", $realtime, what, got, want);
  endtask

  always @(posedge clk) begin
    hit_rec_t want;
    if (rst_n && out_res.valid && out_res.ready) begin
      if (pending_hits.size() == 0) begin
        report("unexpected result beat, hit", out_res.hit, 0);
      end else begin
        want = pending_hits.pop_front();
        list_count++;
        if (want.hit) hit_lists++;
        if (out_res.hit !== want.hit) report("hit", out_res.hit, want.hit);
        if (out_res.hit_distance !== want.distance[30:0])
          report("hit_distance", out_res.hit_distance, want.distance);
      end
    end
  end

  // run guard
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_CAP) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // ---------------------------------------------------------------- idling
  // mostly no gap, often a short one, now and then a long one
  function automatic int pick_gap();
    int r;
    if (quiet) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 4);
    return $urandom_range(20, 150);
  endfunction

  // result side back-pressure
  int ready_hold = 0;
  initial out_res.ready = 1'b0;
  always @(posedge clk) begin
    if (ready_hold == 0) begin
      out_res.ready <= 1'b1;
      if ($urandom_range(0, 3) == 0) ready_hold <= pick_gap();
    end else begin
      out_res.ready <= 1'b0;
      ready_hold <= ready_hold - 1;
    end
  end

  // ---------------------------------------------------------------- driving
  initial begin
    in_tri.valid = 1'b0;
    in_tri.corner_a_x = '0; in_tri.corner_a_y = '0; in_tri.corner_a_z = '0;
    in_tri.corner_b_x = '0; in_tri.corner_b_y = '0; in_tri.corner_b_z = '0;
    in_tri.corner_c_x = '0; in_tri.corner_c_y = '0; in_tri.corner_c_z = '0;
    in_tri.last_triangle = 1'b0;
  end

  // one triangle beat; entered and left right after a rising edge
  task automatic send_triangle(row_t row);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_tri.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tri.valid <= 1'b1;
    in_tri.corner_a_x <= row.tr.a.x[31:0];
    in_tri.corner_a_y <= row.tr.a.y[31:0];
    in_tri.corner_a_z <= row.tr.a.z[31:0];
    in_tri.corner_b_x <= row.tr.b.x[31:0];
    in_tri.corner_b_y <= row.tr.b.y[31:0];
    in_tri.corner_b_z <= row.tr.b.z[31:0];
    in_tri.corner_c_x <= row.tr.c.x[31:0];
    in_tri.corner_c_y <= row.tr.c.y[31:0];
    in_tri.corner_c_z <= row.tr.c.z[31:0];
    in_tri.last_triangle <= row.tr.last;
    do @(posedge clk); while (!in_tri.ready);
    fold_triangle(row);
    tri_count++;
  endtask

  // block is idle once the last list result is in and a test time has passed
  task automatic wait_idle();
    in_tri.valid <= 1'b0;
    while (pending_hits.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
  endtask

  task automatic write_ray(vec_t o, vec_t d, bit first);
    longint vals[7];
    vals = '{o.x, o.y, o.z, d.x, d.y, d.z, longint'(first)};
    for (int i = 0; i < 7; i++) begin
      cfg_we <= 1'b1;
      cfg_index <= rtlh_pkg::cfg_reg_t'(i);
      cfg_data <= vals[i][31:0];
      @(posedge clk);
    end
    cfg_we <= 1'b0;
    ray_org = o;
    ray_dir = d;
    keep_first = first;
  endtask

  // ---------------------------------------------------------------- stimulus
  function automatic longint srnd(int r);
    return longint'($urandom_range(0, 2 * r)) - r;
  endfunction

  function automatic longint full_rnd();
    return longint'($signed($urandom()));
  endfunction

  // right triangle in the plane z, corners at unit grid points, shifted by dx in x
  function automatic tri_t flat_tri(longint z, longint dx, bit flip, bit last);
    tri_t tr;
    tr.a = '{(-1 + dx) * Q, -Q, z};
    tr.b = '{(-1 + dx) * Q, 3 * Q, z};
    tr.c = '{(3 + dx) * Q, -Q, z};
    if (flip) begin
      tr.b = tr.c;
      tr.c = '{(-1 + dx) * Q, 3 * Q, z};
    end
    tr.last = last;
    return tr;
  endfunction

  // triangle whose centroid lies on the ray, so it is hit when front facing
  function automatic tri_t ray_tri(bit last);
    tri_t tr;
    vec_t p, r1, r2;
    longint t;
    t = longint'($urandom_range(0, 1 << 22));
    p = '{sat(ray_org.x + qmul(t, ray_dir.x)), sat(ray_org.y + qmul(t, ray_dir.y)),
          sat(ray_org.z + qmul(t, ray_dir.z))};
    r1 = '{srnd(1 << 19), srnd(1 << 19), srnd(1 << 19)};
    r2 = '{srnd(1 << 19), srnd(1 << 19), srnd(1 << 19)};
    tr.a = '{sat(p.x + r1.x), sat(p.y + r1.y), sat(p.z + r1.z)};
    tr.b = '{sat(p.x + r2.x), sat(p.y + r2.y), sat(p.z + r2.z)};
    tr.c = '{sat(p.x - r1.x - r2.x), sat(p.y - r1.y - r2.y), sat(p.z - r1.z - r2.z)};
    tr.last = last;
    return tr;
  endfunction

  function automatic tri_t noise_tri(bit wide, bit last);
    tri_t tr;
    if (wide) begin
      tr.a = '{full_rnd(), full_rnd(), full_rnd()};
      tr.b = '{full_rnd(), full_rnd(), full_rnd()};
      tr.c = '{full_rnd(), full_rnd(), full_rnd()};
    end else begin
      tr.a = '{srnd(1 << 20), srnd(1 << 20), srnd(1 << 20)};
      tr.b = '{srnd(1 << 20), srnd(1 << 20), srnd(1 << 20)};
      tr.c = '{srnd(1 << 20), srnd(1 << 20), srnd(1 << 20)};
    end
    tr.last = last;
    return tr;
  endfunction

  function automatic row_t checked(tri_t tr);
    row_t r;
    r.tr = tr;
    r.typed = 1'b0;
    r.hit = 1'b0;
    r.distance = 0;
    return r;
  endfunction

  function automatic row_t typed_row(tri_t tr, bit hit, longint distance);
    row_t r;
    r = checked(tr);
    r.typed = 1'b1;
    r.hit = hit;
    r.distance = distance;
    return r;
  endfunction

  row_t table_rows[$];

  initial begin
    vec_t o, d;
    tri_t hi_lo;
    int sent;
    int len;
    int pick;

    ray_org = '{0, 0, 0};
    ray_dir = '{0, 0, Q};
    keep_first = 1'b0;
    list_hit = 1'b0;
    list_best = 0;

    // reset ray: from the origin along +z
    table_rows.push_back(typed_row(flat_tri(5 * Q, 0, 0, 1), 1, 5 * Q));       // plain hit
    table_rows.push_back(typed_row(flat_tri(0, 0, 0, 1), 1, 0));               // hit at t = 0
    begin
      tri_t dg;
      dg = flat_tri(5 * Q, 0, 0, 1);
      dg.b = dg.a;
      dg.c = dg.a;
      table_rows.push_back(typed_row(dg, 0, 0));                               // degenerate
    end
    table_rows.push_back(typed_row(flat_tri(5 * Q, 0, 1, 1), 0, 0));           // back face
    table_rows.push_back(typed_row(flat_tri(-5 * Q, 0, 0, 1), 0, 0));          // behind origin
    table_rows.push_back(typed_row(flat_tri(5 * Q, 10, 0, 1), 0, 0));          // off to the side
    table_rows.push_back(checked(flat_tri(9 * Q, 0, 0, 0)));                   // closest kept
    table_rows.push_back(typed_row(flat_tri(5 * Q, 0, 0, 1), 1, 5 * Q));
    table_rows.push_back(checked(flat_tri(7 * Q, 0, 0, 0)));                   // tie
    table_rows.push_back(typed_row(flat_tri(7 * Q, 0, 0, 1), 1, 7 * Q));
    table_rows.push_back(checked(flat_tri(32767 * Q, 0, 0, 1)));               // far plane
    table_rows.push_back(checked(flat_tri(SAT_HI, 0, 0, 1)));                  // top of range
    hi_lo.a = '{SAT_HI, SAT_LO, SAT_HI};
    hi_lo.b = '{SAT_LO, SAT_HI, SAT_LO};
    hi_lo.c = '{SAT_HI, SAT_HI, SAT_LO};
    hi_lo.last = 1'b1;
    table_rows.push_back(checked(hi_lo));                                      // field extremes
    hi_lo.a = '{SAT_LO, SAT_LO, SAT_LO};
    hi_lo.b = '{0, 0, 0};
    hi_lo.c = '{SAT_HI, -1, SAT_LO};
    table_rows.push_back(checked(hi_lo));
    for (int i = 0; i < 4; i++) table_rows.push_back(checked(noise_tri(1, i == 3)));

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (table_rows[i]) send_triangle(table_rows[i]);
    wait_idle();

    // first-hit mode on the reset ray: the far triangle comes first and stays
    write_ray('{0, 0, 0}, '{0, 0, Q}, 1);
    send_triangle(checked(flat_tri(9 * Q, 0, 0, 0)));
    send_triangle(checked(flat_tri(5 * Q, 0, 0, 1)));
    wait_idle();

    // random lists under a run of ray setups, extremes included
    for (int ph = 0; ph < 8; ph++) begin
      case (ph)
        2: begin
          o = '{SAT_HI, SAT_HI, SAT_HI};
          d = '{SAT_LO, SAT_LO, SAT_LO};
        end
        5: begin
          o = '{SAT_LO, SAT_LO, SAT_LO};
          d = '{SAT_HI, SAT_HI, SAT_HI};
        end
        default: begin
          o = '{srnd(1 << 20), srnd(1 << 20), srnd(1 << 20)};
          d = '{srnd(1 << 17), srnd(1 << 17), srnd(1 << 17)};
        end
      endcase
      write_ray(o, d, ph[0]);
      sent = 0;
      while (sent < 50) begin
        quiet = ($urandom_range(0, 4) == 0);
        // sender holds off until the block has delivered everything
        if (($urandom_range(0, 9) == 0) && (pending_hits.size() != 0)) begin
          in_tri.valid <= 1'b0;
          while (pending_hits.size() != 0) @(posedge clk);
        end
        len = $urandom_range(1, 5);
        for (int k = 0; k < len; k++) begin
          pick = $urandom_range(0, 99);
          if (pick < 70) send_triangle(checked(ray_tri(k == len - 1)));
          else if (pick < 90) send_triangle(checked(noise_tri(0, k == len - 1)));
          else send_triangle(checked(noise_tri(1, k == len - 1)));
        end
        sent += len;
      end
      quiet = 1'b0;
      wait_idle();
    end

    $display("covered %0d triangles in %0d lists, %0d of them with a hit",
             tri_count, list_count, hit_lists);
    $display("ray setups: reset, first-hit, random small and both range extremes");
    if (errors == 0 && pending_hits.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
